>>> rtl/rmth_pkg.sv
// ----------------------------------------------------------------------------
// rmth_pkg: shared types and constants for the running median block
// Sizes of the sample store, the cell chain command and its opcodes.
// ----------------------------------------------------------------------------
package rmth_pkg;

   localparam int CAPACITY    = 1024;
   localparam int SAMPLE_W    = 32;
   localparam int MEDIAN_W    = SAMPLE_W + 1;
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   // lower half holds ceil(n/2), upper half floor(n/2); both chains use the larger depth
   localparam int CHAIN_DEPTH = (CAPACITY + 1) / 2;

   typedef enum logic [1:0] {
      OP_HOLD = 2'd0,
      OP_INS  = 2'd1,
      OP_REPL = 2'd2,
      OP_PUSH = 2'd3
   } chain_op_type;

   typedef struct packed {
      chain_op_type               op;
      logic signed [SAMPLE_W-1:0] x;
   } chain_cmd_type;

endpackage

>>> rtl/rmth_cell.sv
// ----------------------------------------------------------------------------
// rmth_cell: one slot of an ascending sorted chain
// Holds one value; on each command takes its own, its neighbor's or the new value.
// ----------------------------------------------------------------------------
module rmth_cell (
   input  logic                                clock,
   input  rmth_pkg::chain_cmd_type             cmd,
   input  logic                                occ,
   input  logic signed [rmth_pkg::SAMPLE_W-1:0] prev_value,
   input  logic                                prev_le,
   input  logic signed [rmth_pkg::SAMPLE_W-1:0] next_value,
   input  logic                                next_le,
   output logic signed [rmth_pkg::SAMPLE_W-1:0] value,
   output logic                                le
);
   import rmth_pkg::*;

   logic signed [SAMPLE_W-1:0] value_ff;
   logic signed [SAMPLE_W-1:0] value_in;

   assign le    = occ && (value_ff <= cmd.x);
   assign value = value_ff;

   always_comb begin
      case (cmd.op)
         OP_HOLD: value_in = value_ff;
         // insert: keep if at or below x, else x lands here or we take the left value
         OP_INS:  value_in = le ? value_ff : (prev_le ? cmd.x : prev_value);
         // drop head and insert x (x not below head): slide left up to x
         OP_REPL: value_in = next_le ? next_value : (le ? cmd.x : value_ff);
         OP_PUSH: value_in = prev_value;
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

>>> rtl/rmth_chain.sv
// ----------------------------------------------------------------------------
// rmth_chain: row of sorted cells, smallest value at the head
// Cells below the fill level are occupied; the head value is exported.
// ----------------------------------------------------------------------------
module rmth_chain (
   input  logic                                 clock,
   input  rmth_pkg::chain_cmd_type              cmd,
   input  logic [rmth_pkg::CNT_W-1:0]           fill,
   output logic signed [rmth_pkg::SAMPLE_W-1:0] head
);
   import rmth_pkg::*;

   logic signed [SAMPLE_W-1:0] vals [CHAIN_DEPTH];
   logic                       les  [CHAIN_DEPTH];

   genvar i;
   generate
      for (i = 0; i < CHAIN_DEPTH; i++) begin : g_cell
         logic signed [SAMPLE_W-1:0] pv;
         logic                       pl;
         logic signed [SAMPLE_W-1:0] nv;
         logic                       nl;
         logic                       occ;

         assign occ = (fill > CNT_W'(i));

         if (i == 0) begin : g_first
            assign pv = cmd.x;
            assign pl = 1'b1;
         end else begin : g_mid
            assign pv = vals[i-1];
            assign pl = les[i-1];
         end

         if (i == CHAIN_DEPTH - 1) begin : g_last
            assign nv = vals[i];
            assign nl = 1'b0;
         end else begin : g_inner
            assign nv = vals[i+1];
            assign nl = les[i+1];
         end

         rmth_cell u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .occ        (occ),
            .prev_value (pv),
            .prev_le    (pl),
            .next_value (nv),
            .next_le    (nl),
            .value      (vals[i]),
            .le         (les[i])
         );
      end
   endgenerate

   assign head = vals[0];

endmodule

>>> rtl/running_median_two_heap_top.sv
// ----------------------------------------------------------------------------
// running_median_two_heap_top: running median over a stream of samples
// Lower and upper halves kept in two sorted cell chains; median read at heads.
// ----------------------------------------------------------------------------
//   channel | direction | payload
//   req     | in        | sample (signed, SAMPLE_W)
//   rsp     | out       | median_doubled, sample_count, overflow
//
// A taken request updates one or both chains, unless full, in that cycle;
// its response is registered from the chain heads once rsp is free. With rsp
// drained the block takes one request per cycle; a stalled response holds off
// the next request after one more is taken. Reset clears the count and the
// handshake flags; cell contents are unused until written. Lower chain stores
// inverted samples so that both chains keep their extreme value at the head.
module running_median_two_heap_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [rmth_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [rmth_pkg::MEDIAN_W-1:0] rsp_median_doubled,
   output logic [rmth_pkg::CNT_W-1:0]           rsp_sample_count,
   output logic                                 rsp_overflow
);
   import rmth_pkg::*;

   logic [CNT_W-1:0]           count_ff,   count_in;
   logic                       pend_ff,    pend_in;
   logic                       pend_ovf_ff, pend_ovf_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [MEDIAN_W-1:0] median_ff,  median_in;
   logic [CNT_W-1:0]           rcount_ff,  rcount_in;
   logic                       rovf_ff,    rovf_in;

   chain_cmd_type              low_cmd, up_cmd;
   logic [CNT_W-1:0]           low_fill, up_fill;
   logic signed [SAMPLE_W-1:0] low_head, up_head, low_val;
   logic                       accept, full, load_rsp;

   assign low_val  = ~low_head;
   assign low_fill = (count_ff >> 1) + CNT_W'(count_ff[0]);
   assign up_fill  = count_ff >> 1;
   assign full     = (count_ff == CNT_W'(CAPACITY));

   assign load_rsp  = pend_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !pend_ff || load_rsp;
   assign accept    = req_valid && req_ready;

   always_comb begin
      low_cmd.op = OP_HOLD;
      low_cmd.x  = ~req_sample;
      up_cmd.op  = OP_HOLD;
      up_cmd.x   = req_sample;
      count_in   = count_ff;
      if (accept && !full) begin
         count_in = count_ff + 1'b1;
         if (!count_ff[0]) begin
            // halves equal: lower grows
            if (count_ff != '0 && req_sample > up_head) begin
               up_cmd.op  = OP_REPL;
               low_cmd.op = OP_PUSH;
               low_cmd.x  = ~up_head;
            end else begin
               low_cmd.op = OP_INS;
            end
         end else begin
            // lower ahead by one: upper grows
            if (req_sample < low_val) begin
               low_cmd.op = OP_REPL;
               up_cmd.op  = OP_PUSH;
               up_cmd.x   = low_val;
            end else begin
               up_cmd.op = OP_INS;
            end
         end
      end
   end

   always_comb begin
      pend_in      = pend_ff;
      pend_ovf_in  = pend_ovf_ff;
      rsp_valid_in = rsp_valid_ff;
      median_in    = median_ff;
      rcount_in    = rcount_ff;
      rovf_in      = rovf_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rcount_in    = count_ff;
         rovf_in      = pend_ovf_ff;
         if (count_ff[0]) begin
            median_in = {low_val, 1'b0};
         end else begin
            median_in = {low_val[SAMPLE_W-1], low_val} + {up_head[SAMPLE_W-1], up_head};
         end
         pend_in = 1'b0;
      end
      if (accept) begin
         pend_in     = 1'b1;
         pend_ovf_in = full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ovf_ff <= pend_ovf_in;
      median_ff   <= median_in;
      rcount_ff   <= rcount_in;
      rovf_ff     <= rovf_in;
   end

   rmth_chain u_low (
      .clock (clock),
      .cmd   (low_cmd),
      .fill  (low_fill),
      .head  (low_head)
   );

   rmth_chain u_up (
      .clock (clock),
      .cmd   (up_cmd),
      .fill  (up_fill),
      .head  (up_head)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_median_doubled = median_ff;
   assign rsp_sample_count   = rcount_ff;
   assign rsp_overflow       = rovf_ff;

endmodule

>>> rtl/rmth_checker.sv
// ----------------------------------------------------------------------------
// rmth_checker: port-level checks for the running median block
// Watches the request and response channels; bound to the top level.
// ----------------------------------------------------------------------------
module rmth_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic signed [rmth_pkg::SAMPLE_W-1:0] req_sample,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [rmth_pkg::MEDIAN_W-1:0] rsp_median_doubled,
   input logic [rmth_pkg::CNT_W-1:0]           rsp_sample_count,
   input logic                                 rsp_overflow
);
   import rmth_pkg::*;

   // stalled request holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_sample))
      else $error("req changed while stalled");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_median_doubled)
         && $stable(rsp_sample_count) && $stable(rsp_overflow))
      else $error("rsp changed while stalled");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sample_count != '0 && rsp_sample_count <= CNT_W'(CAPACITY))
      else $error("rsp_sample_count out of range");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_sample_count == CNT_W'(CAPACITY))
      else $error("overflow with store not full");

   // a response follows each taken request
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##2 rsp_valid)
      else $error("no response after request");

endmodule

bind running_median_two_heap_top rmth_checker u_rmth_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .req_sample         (req_sample),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_median_doubled (rsp_median_doubled),
   .rsp_sample_count   (rsp_sample_count),
   .rsp_overflow       (rsp_overflow)
);

>>> tb/running_median_two_heap_top_tb.sv
// ----------------------------------------------------------------------------
// running_median_two_heap_top_tb: self-checking bench for the running median
// Streams signed samples through the block, predicts every response from a
// sorted copy of the stored samples and checks each one on arrival. The run
// covers sample extremes, repeated values, random data and a full store.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module running_median_two_heap_top_tb;
   import rmth_pkg::*;

   localparam int RANDOM_SAMPLES   = 800;
   localparam int OVERFLOW_SAMPLES = 40;
   localparam int IDLE_LIMIT       = 2000;

   typedef struct {
      logic signed [MEDIAN_W-1:0] median_doubled;
      logic [CNT_W-1:0]           sample_count;
      logic                       overflow;
   } median_result_type;

   // Keeps a sorted copy of the stored samples and the responses still owed.
   class median_scoreboard;
      longint            sorted_samples[$];
      median_result_type expected_medians[$];
      int                failures;

      function int pending();
         return expected_medians.size();
      endfunction

      function void note_request(logic signed [SAMPLE_W-1:0] sample);
         median_result_type r;
         longint            v;
         longint            dbl;
         int                pos;
         int                n;
         v = sample;
         r.overflow = (sorted_samples.size() >= CAPACITY);
         if (!r.overflow) begin
            // equal values go after the stored ones
            pos = sorted_samples.size();
            while (pos > 0 && sorted_samples[pos-1] > v)
               pos--;
            sorted_samples.insert(pos, v);
         end
         n = sorted_samples.size();
         if (n % 2)
            dbl = 2 * sorted_samples[n/2];
         else
            dbl = sorted_samples[n/2-1] + sorted_samples[n/2];
         r.median_doubled = dbl[MEDIAN_W-1:0];
         r.sample_count   = CNT_W'(n);
         expected_medians.push_back(r);
      endfunction

      function void check_response(logic signed [MEDIAN_W-1:0] median_doubled,
                                   logic [CNT_W-1:0] sample_count, logic overflow);
         median_result_type e;
         if (expected_medians.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected response: median_doubled %0d count %0d overflow %0b",
                        median_doubled, sample_count, overflow);
            return;
         end
         e = expected_medians.pop_front();
         if (median_doubled !== e.median_doubled || sample_count !== e.sample_count ||
             overflow !== e.overflow) begin
            failures++;
            if (failures <= 10)
               $display("median mismatch: expected median_doubled %0d count %0d overflow %0b,",
                        e.median_doubled, e.sample_count, e.overflow,
                        " got %0d %0d %0b", median_doubled, sample_count, overflow);
         end
      endfunction
   endclass

   logic                       clock;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [MEDIAN_W-1:0] rsp_median_doubled;
   logic [CNT_W-1:0]           rsp_sample_count;
   logic                       rsp_overflow;

   median_scoreboard sb = new();
   int               idle_cycles;
   int               burst_left;
   int               stall_mode;
   int               mode_left;

   running_median_two_heap_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_median_doubled (rsp_median_doubled),
      .rsp_sample_count   (rsp_sample_count),
      .rsp_overflow       (rsp_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // request/response monitor and idle watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_request(req_sample);
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_median_doubled, rsp_sample_count, rsp_overflow);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("** running_median_two_heap_top: FAILED **");
            $finish;
         end
      end
   end

   // receiver: switches between always ready, coin flip and long stalls
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         mode_left  = $urandom_range(10, 60);
      end else begin
         mode_left--;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   function logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return {1'b1, {(SAMPLE_W-1){1'b0}}};
         1: return {1'b0, {(SAMPLE_W-1){1'b1}}};
         2: return $signed($urandom_range(0, 16)) - 8;
         3: return {1'b0, {(SAMPLE_W-1){1'b1}}} - $urandom_range(0, 15);
         4: return {1'b1, {(SAMPLE_W-1){1'b0}}} + $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   task send_sample(input logic signed [SAMPLE_W-1:0] sample);
      @(negedge clock);
      req_valid  <= 1'b1;
      req_sample <= sample;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   task hold_requests(input int cycles);
      @(negedge clock);
      req_valid  <= 1'b0;
      req_sample <= $urandom;
      repeat (cycles - 1)
         @(negedge clock);
   endtask

   // bursts of random length separated by random gaps
   task paced_send(input logic signed [SAMPLE_W-1:0] sample);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0)
            hold_requests(gap);
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      send_sample(sample);
   endtask

   task wait_for_drain();
      hold_requests(1);
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   initial begin
      logic signed [SAMPLE_W-1:0] directed[$];
      int                         sent;
      idle_cycles = 0;
      burst_left  = 0;
      stall_mode  = 0;
      mode_left   = 0;
      sent        = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // both sample extremes, largest sum of middles, repeats, sign edges
      directed = '{32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                   32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, -1, 1, 5, 5, 5, 5,
                   32'sh5555_5555, 32'shAAAA_AAAA, -2, 2, 32'sh0000_FFFF,
                   32'shFFFF_0000, 3};
      foreach (directed[i]) begin
         send_sample(directed[i]);
         sent++;
      end
      wait_for_drain();

      for (int i = 0; i < RANDOM_SAMPLES; i++) begin
         if (i == RANDOM_SAMPLES / 2)
            wait_for_drain();
         paced_send(pick_sample());
         sent++;
      end

      // fill the store, then keep sending so every further sample is dropped
      while (sent < CAPACITY + OVERFLOW_SAMPLES) begin
         paced_send(pick_sample());
         sent++;
      end

      wait_for_drain();
      repeat (5) @(posedge clock);
      if (sb.pending() != 0)
         $display("%0d responses never arrived", sb.pending());
      if (sb.failures == 0 && sb.pending() == 0)
         $display("** running_median_two_heap_top: PASSED **");
      else
         $display("** running_median_two_heap_top: FAILED **");
      $finish;
   end

endmodule
